// ===== rtl/mbrtu_pkg.sv =====
// Shared constants and types for the Modbus RTU request framer.
// Depends on nothing; every other file but mbrtu_if imports it.
package mbrtu_pkg;

    localparam logic [1:0] CMD_READ_COILS = 2'd0;
    localparam logic [1:0] CMD_READ_HOLD  = 2'd1;
    localparam logic [1:0] CMD_WRITE_HDR  = 2'd2;
    localparam logic [1:0] CMD_DATA_WORD  = 2'd3;

    localparam logic [7:0] FC_READ_COILS  = 8'h01;
    localparam logic [7:0] FC_READ_HOLD   = 8'h03;
    localparam logic [7:0] FC_WRITE_MULTI = 8'h10;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_NO_WRITE   = 2'd1;
    localparam logic [1:0] ERR_COUNT      = 2'd2;

    localparam logic [15:0] MAX_WRITE_WORDS = 16'd123;
    localparam int          WORDS_W         = 7;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic       init;
        logic       upd;
        logic [7:0] data;
    } t_crc_ctl;

    typedef struct packed {
        logic       valid;
        logic [7:0] tx_byte;
        logic       frame_end;
        logic [1:0] error_code;
    } t_beat;

endpackage

// ===== rtl/mbrtu_if.sv =====
// Handshake interfaces for the request items and the transmitted frame bytes.
// Depends on nothing.
interface mbrtu_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  station_id;
    logic [15:0] start_addr;
    logic [15:0] reg_count;
    logic [15:0] data_word;

    modport source (output valid, cmd, station_id, start_addr, reg_count, data_word,
                    input ready);
    modport sink (input valid, cmd, station_id, start_addr, reg_count, data_word,
                  output ready);
endinterface

interface mbrtu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       frame_end;
    logic [1:0] error_code;

    modport source (output valid, tx_byte, frame_end, error_code, input ready);
    modport sink (input valid, tx_byte, frame_end, error_code, output ready);
endinterface

// ===== rtl/mbrtu_crc.sv =====
// Running Modbus CRC-16 register with a one-byte-per-cycle update unit.
// Depends on mbrtu_pkg.
module mbrtu_crc
    import mbrtu_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_crc_ctl      i_ctl,
    output logic [15:0]   o_crc
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    always_comb begin
        priority if (i_ctl.init) begin
            n_crc = CRC_INIT;
        end else if (i_ctl.upd) begin
            n_crc = crc_byte(r_crc, i_ctl.data);
        end else begin
            n_crc = r_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

// ===== rtl/mbrtu_seq.sv =====
// Frame sequencer: holds one request item and steps through its bytes, one per beat.
// Depends on mbrtu_pkg and mbrtu_if.
module mbrtu_seq
    import mbrtu_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    mbrtu_req_if.sink     i_req,
    input  logic          i_advance,
    input  logic [15:0]   i_crc,
    output t_crc_ctl      o_crc_ctl,
    output t_beat         o_beat
);

    localparam logic [3:0] S_SID  = 4'd0;
    localparam logic [3:0] S_FC   = 4'd1;
    localparam logic [3:0] S_AH   = 4'd2;
    localparam logic [3:0] S_AL   = 4'd3;
    localparam logic [3:0] S_CH   = 4'd4;
    localparam logic [3:0] S_CL   = 4'd5;
    localparam logic [3:0] S_BC   = 4'd6;
    localparam logic [3:0] S_DH   = 4'd7;
    localparam logic [3:0] S_DL   = 4'd8;
    localparam logic [3:0] S_CRCL = 4'd9;
    localparam logic [3:0] S_CRCH = 4'd10;
    localparam logic [3:0] S_ERR  = 4'd11;

    logic               r_busy;
    logic [3:0]         r_step;
    logic [1:0]         r_cmd;
    logic [7:0]         r_sid;
    logic [15:0]        r_addr;
    logic [15:0]        r_cnt;
    logic [15:0]        r_word;
    logic [1:0]         r_err;
    logic [WORDS_W-1:0] r_words_left;
    logic               r_write_open;

    logic               n_busy;
    logic [3:0]         n_step;
    logic [WORDS_W-1:0] n_words_left;
    logic               n_write_open;

    logic               accept;
    logic               emit;
    logic               is_header;
    logic [7:0]         fc;
    logic [7:0]         beat_byte;
    logic               beat_end;
    logic               beat_data;

    assign i_req.ready = !r_busy;
    assign accept      = i_req.valid && !r_busy;
    assign emit        = r_busy && i_advance;
    assign is_header   = (i_req.cmd != CMD_DATA_WORD);

    always_comb begin
        unique case (r_cmd)
            CMD_READ_COILS: fc = FC_READ_COILS;
            CMD_READ_HOLD:  fc = FC_READ_HOLD;
            default:        fc = FC_WRITE_MULTI;
        endcase
    end

    always_comb begin
        beat_end  = 1'b0;
        beat_data = 1'b1;
        unique case (r_step)
            S_SID:   beat_byte = r_sid;
            S_FC:    beat_byte = fc;
            S_AH:    beat_byte = r_addr[15:8];
            S_AL:    beat_byte = r_addr[7:0];
            S_CH:    beat_byte = r_cnt[15:8];
            S_CL:    beat_byte = r_cnt[7:0];
            S_BC:    beat_byte = {r_cnt[6:0], 1'b0};
            S_DH:    beat_byte = r_word[15:8];
            S_DL:    beat_byte = r_word[7:0];
            S_CRCL: begin
                beat_byte = i_crc[7:0];
                beat_data = 1'b0;
            end
            S_CRCH: begin
                beat_byte = i_crc[15:8];
                beat_end  = 1'b1;
                beat_data = 1'b0;
            end
            default: begin
                beat_byte = 8'h00;
                beat_end  = 1'b1;
                beat_data = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_beat.valid      = emit;
        o_beat.tx_byte    = beat_byte;
        o_beat.frame_end  = beat_end;
        o_beat.error_code = (r_step == S_ERR) ? r_err : ERR_NONE;
    end

    always_comb begin
        o_crc_ctl.init = (accept && is_header) || (emit && r_step == S_CRCH);
        o_crc_ctl.upd  = emit && beat_data;
        o_crc_ctl.data = beat_byte;
    end

    always_comb begin
        n_busy       = r_busy;
        n_step       = r_step;
        n_words_left = r_words_left;
        n_write_open = r_write_open;
        if (accept) begin
            n_busy = 1'b1;
            if (!is_header) begin
                n_step = r_write_open ? S_DH : S_ERR;
            end else begin
                n_words_left = '0;
                n_write_open = 1'b0;
                if (i_req.cmd == CMD_WRITE_HDR && i_req.reg_count > MAX_WRITE_WORDS) begin
                    n_step = S_ERR;
                end else begin
                    n_step = S_SID;
                end
            end
        end else if (emit) begin
            unique case (r_step)
                S_SID: n_step = S_FC;
                S_FC:  n_step = S_AH;
                S_AH:  n_step = S_AL;
                S_AL:  n_step = S_CH;
                S_CH:  n_step = S_CL;
                S_CL:  n_step = (r_cmd == CMD_WRITE_HDR) ? S_BC : S_CRCL;
                S_BC: begin
                    if (r_cnt == 16'd0) begin
                        n_step = S_CRCL;
                    end else begin
                        n_busy       = 1'b0;
                        n_words_left = r_cnt[WORDS_W-1:0];
                        n_write_open = 1'b1;
                    end
                end
                S_DH:  n_step = S_DL;
                S_DL: begin
                    n_words_left = r_words_left - {{(WORDS_W-1){1'b0}}, 1'b1};
                    if (r_words_left == {{(WORDS_W-1){1'b0}}, 1'b1}) begin
                        n_write_open = 1'b0;
                        n_step       = S_CRCL;
                    end else begin
                        n_busy = 1'b0;
                    end
                end
                S_CRCL: n_step = S_CRCH;
                default: n_busy = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_step       <= S_SID;
            r_words_left <= '0;
            r_write_open <= 1'b0;
        end else begin
            r_busy       <= n_busy;
            r_step       <= n_step;
            r_words_left <= n_words_left;
            r_write_open <= n_write_open;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_req.cmd;
            r_sid  <= i_req.station_id;
            r_addr <= i_req.start_addr;
            r_cnt  <= i_req.reg_count;
            r_word <= i_req.data_word;
            r_err  <= is_header ? ERR_COUNT : ERR_NO_WRITE;
        end
    end

endmodule

// ===== rtl/modbus_rtu_request_framer_top.sv =====
// Modbus RTU master request framer, top level.
// Depends on mbrtu_pkg, mbrtu_if, mbrtu_crc and mbrtu_seq.
//
// The request channel takes one item per beat: a read-coils, read-holding or
// write-registers header, or one data word of an open write. The byte channel
// returns the frame one byte per beat, CRC low byte first, with frame_end on
// the last CRC byte. Error items give a single zero byte with frame_end set
// and the error code.
// The first byte of an item is presented from the output register after the item
// is accepted, and bytes follow one per cycle while the receiver takes them. An
// item that yields n bytes (1 to 9) holds the request channel until the stepper
// has passed on its last byte, so no new item is taken before then; the single
// byte stepper with its CRC unit, one byte per cycle, sets that pace.
// The last byte waits in the output register while the next item is taken.
// When the receiver stalls, the stepper pauses with it and no byte is lost.
// Reset empties the output register, closes any open write and sets the CRC
// to 0xFFFF.
module modbus_rtu_request_framer_top
    import mbrtu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbrtu_req_if.sink   i_req,
    mbrtu_byte_if.source o_tx
);

    t_crc_ctl    crc_ctl;
    t_beat       beat;
    logic [15:0] crc;
    logic        advance;

    logic        r_out_valid;
    logic [7:0]  r_tx_byte;
    logic        r_frame_end;
    logic [1:0]  r_error_code;

    assign advance = !r_out_valid || o_tx.ready;

    mbrtu_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .o_crc   (crc)
    );

    mbrtu_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_advance (advance),
        .i_crc     (crc),
        .o_crc_ctl (crc_ctl),
        .o_beat    (beat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (beat.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_tx.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (beat.valid) begin
            r_tx_byte    <= beat.tx_byte;
            r_frame_end  <= beat.frame_end;
            r_error_code <= beat.error_code;
        end
    end

    assign o_tx.valid      = r_out_valid;
    assign o_tx.tx_byte    = r_tx_byte;
    assign o_tx.frame_end  = r_frame_end;
    assign o_tx.error_code = r_error_code;

endmodule

// ===== tb/sv/tb_modbus_rtu_request_framer_top.sv =====
// Self-checking testbench for the Modbus RTU request framer top level.
// Depends on mbrtu_pkg, mbrtu_if and the RTL; predicts every frame byte with its
// own CRC-16 model and compares each output beat in order.
module tb_modbus_rtu_request_framer_top;
    import mbrtu_pkg::*;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  station_id;
        logic [15:0] start_addr;
        logic [15:0] reg_count;
        logic [15:0] data_word;
    } t_request;

    typedef struct {
        logic [7:0] tx_byte;
        logic       frame_end;
        logic [1:0] error_code;
    } t_frame_beat;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic hold_rx = 1'b0;
    logic quiet = 1'b0;
    int   mismatch_count = 0;

    logic [15:0] model_crc = CRC_INIT;
    logic [6:0]  model_words_left = '0;
    logic        model_write_open = 1'b0;
    t_frame_beat frame_byte_q[$];
    t_frame_beat next_beat;

    mbrtu_req_if  req_bus();
    mbrtu_byte_if tx_bus();

    modbus_rtu_request_framer_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus.sink),
        .o_tx    (tx_bus.source)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function void emit_frame_byte(logic [7:0] b);
        model_crc = crc16_step(model_crc, b);
        frame_byte_q.push_back('{tx_byte: b, frame_end: 1'b0, error_code: ERR_NONE});
    endfunction

    function void emit_crc();
        frame_byte_q.push_back('{tx_byte: model_crc[7:0], frame_end: 1'b0,
                                 error_code: ERR_NONE});
        frame_byte_q.push_back('{tx_byte: model_crc[15:8], frame_end: 1'b1,
                                 error_code: ERR_NONE});
        model_crc = CRC_INIT;
    endfunction

    function void emit_error(logic [1:0] code);
        frame_byte_q.push_back('{tx_byte: 8'h00, frame_end: 1'b1, error_code: code});
    endfunction

    function void predict_frame(t_request r);
        logic [7:0] fc;
        if (r.cmd == CMD_DATA_WORD) begin
            if (!model_write_open) begin
                emit_error(ERR_NO_WRITE);
                return;
            end
            emit_frame_byte(r.data_word[15:8]);
            emit_frame_byte(r.data_word[7:0]);
            model_words_left = model_words_left - 7'd1;
            if (model_words_left == 7'd0) begin
                emit_crc();
                model_write_open = 1'b0;
            end
            return;
        end
        model_write_open = 1'b0;
        model_words_left = '0;
        model_crc = CRC_INIT;
        if (r.cmd == CMD_WRITE_HDR && r.reg_count > MAX_WRITE_WORDS) begin
            emit_error(ERR_COUNT);
            return;
        end
        case (r.cmd)
            CMD_READ_COILS: fc = FC_READ_COILS;
            CMD_READ_HOLD:  fc = FC_READ_HOLD;
            default:        fc = FC_WRITE_MULTI;
        endcase
        emit_frame_byte(r.station_id);
        emit_frame_byte(fc);
        emit_frame_byte(r.start_addr[15:8]);
        emit_frame_byte(r.start_addr[7:0]);
        emit_frame_byte(r.reg_count[15:8]);
        emit_frame_byte(r.reg_count[7:0]);
        if (r.cmd == CMD_WRITE_HDR) begin
            emit_frame_byte({r.reg_count[6:0], 1'b0});
            if (r.reg_count == 16'd0) begin
                emit_crc();
            end else begin
                model_words_left = r.reg_count[6:0];
                model_write_open = 1'b1;
            end
        end else begin
            emit_crc();
        end
    endfunction

    function automatic t_request random_request(logic [1:0] cmd);
        t_request r;
        r.cmd        = cmd;
        r.station_id = 8'($urandom);
        r.start_addr = 16'($urandom);
        r.reg_count  = 16'($urandom);
        r.data_word  = 16'($urandom);
        return r;
    endfunction

    task automatic send_request(input t_request r);
        if (!quiet) begin
            while ($urandom_range(0, 99) < 8) begin
                req_bus.valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_bus.valid      <= 1'b1;
        req_bus.cmd        <= r.cmd;
        req_bus.station_id <= r.station_id;
        req_bus.start_addr <= r.start_addr;
        req_bus.reg_count  <= r.reg_count;
        req_bus.data_word  <= r.data_word;
        @(posedge clk);
        while (!req_bus.ready) @(posedge clk);
        predict_frame(r);
    endtask

    task automatic send_write_burst(input int count, input int n_words);
        t_request r;
        r = random_request(CMD_WRITE_HDR);
        r.reg_count = 16'(count);
        send_request(r);
        repeat (n_words) send_request(random_request(CMD_DATA_WORD));
    endtask

    task automatic hold_receiver(input int n_cycles);
        hold_rx <= 1'b1;
        repeat (n_cycles) @(posedge clk);
        hold_rx <= 1'b0;
    endtask

    task automatic test_read_frames();
        send_request('{CMD_READ_COILS, 8'h00, 16'h0000, 16'h0000, 16'h0000});
        send_request('{CMD_READ_COILS, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_request('{CMD_READ_HOLD, 8'h00, 16'h0000, 16'h0000, 16'hFFFF});
        send_request('{CMD_READ_HOLD, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000});
        send_request('{CMD_READ_HOLD, 8'h11, 16'h006B, 16'h0003, 16'h5A5A});
        send_request('{CMD_READ_COILS, 8'h01, 16'h0013, 16'h0025, 16'hA5A5});
    endtask

    task automatic test_write_frames();
        send_request('{CMD_WRITE_HDR, 8'h11, 16'h0001, 16'h0002, 16'hFFFF});
        send_request('{CMD_DATA_WORD, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h000A});
        send_request('{CMD_DATA_WORD, 8'h00, 16'h0000, 16'h0000, 16'h0102});
        send_request('{CMD_WRITE_HDR, 8'h22, 16'hFFFF, 16'h0000, 16'h1234});
        send_request('{CMD_WRITE_HDR, 8'h33, 16'h0100, 16'd124, 16'h0000});
        send_request('{CMD_WRITE_HDR, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_request('{CMD_DATA_WORD, 8'h44, 16'h1111, 16'h0001, 16'hBEEF});
        send_request('{CMD_WRITE_HDR, 8'h55, 16'h2000, 16'h0003, 16'h0000});
        send_request('{CMD_DATA_WORD, 8'h00, 16'h0000, 16'h0000, 16'hFFFF});
        send_request('{CMD_READ_HOLD, 8'h66, 16'h0040, 16'h0010, 16'h0000});
        send_request('{CMD_DATA_WORD, 8'h00, 16'h0000, 16'h0000, 16'h0000});
        send_request('{CMD_WRITE_HDR, 8'h00, 16'h0000, 16'h0001, 16'h0000});
        send_request('{CMD_DATA_WORD, 8'h00, 16'h0000, 16'h0000, 16'h0000});
        send_request('{CMD_WRITE_HDR, 8'h77, 16'h8000, 16'h0002, 16'h0000});
        send_request('{CMD_DATA_WORD, 8'h00, 16'h0000, 16'h0000, 16'h8001});
        send_request('{CMD_WRITE_HDR, 8'h88, 16'h0000, 16'd0, 16'h0000});
    endtask

    // The receiver stalls while the sender keeps offering a full-size write.
    task automatic test_full_write_under_stall();
        fork
            hold_receiver(150);
        join_none
        send_write_burst(int'(MAX_WRITE_WORDS), int'(MAX_WRITE_WORDS));
    endtask

    task automatic test_back_to_back();
        int count;
        quiet <= 1'b1;
        repeat (8) begin
            if ($urandom_range(0, 1) == 0) begin
                count = $urandom_range(0, 4);
                send_write_burst(count, count);
            end else begin
                send_request(random_request($urandom_range(0, 1) == 0 ?
                                            CMD_READ_COILS : CMD_READ_HOLD));
            end
        end
        quiet <= 1'b0;
    endtask

    task automatic test_random_traffic();
        int sent;
        int pick;
        int count;
        t_request r;
        sent = 0;
        while (sent < 110) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                count = $urandom_range(0, 6);
                send_write_burst(count, count);
                sent += count + 1;
            end else if (pick < 85) begin
                send_request(random_request(pick < 72 ? CMD_READ_COILS : CMD_READ_HOLD));
                sent++;
            end else if (pick < 90) begin
                count = $urandom_range(2, 8);
                pick = $urandom_range(1, count - 1);
                send_write_burst(count, pick);
                sent += pick + 1;
            end else if (pick < 95) begin
                send_request(random_request(CMD_DATA_WORD));
                sent++;
            end else begin
                r = random_request(CMD_WRITE_HDR);
                r.reg_count = 16'($urandom_range(124, 65535));
                send_request(r);
                sent++;
            end
        end
    endtask

    task automatic wait_for_drain();
        req_bus.valid <= 1'b0;
        while (frame_byte_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial begin
        tx_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            tx_bus.ready <= !hold_rx && (quiet || $urandom_range(0, 99) >= 8);
        end
    end

    always @(posedge clk) begin
        if (rst_n && tx_bus.valid && tx_bus.ready) begin
            if (frame_byte_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected beat: expected none, got %02h/%0b/%0d",
                         $time, tx_bus.tx_byte, tx_bus.frame_end, tx_bus.error_code);
            end else begin
                next_beat = frame_byte_q.pop_front();
                if (tx_bus.tx_byte !== next_beat.tx_byte ||
                    tx_bus.frame_end !== next_beat.frame_end ||
                    tx_bus.error_code !== next_beat.error_code) begin
                    mismatch_count++;
                    $display("%0t: beat mismatch: expected %02h/%0b/%0d, got %02h/%0b/%0d",
                             $time, next_beat.tx_byte, next_beat.frame_end,
                             next_beat.error_code, tx_bus.tx_byte, tx_bus.frame_end,
                             tx_bus.error_code);
                end
            end
        end
    end

    initial begin
        req_bus.valid      <= 1'b0;
        req_bus.cmd        <= CMD_READ_COILS;
        req_bus.station_id <= '0;
        req_bus.start_addr <= '0;
        req_bus.reg_count  <= '0;
        req_bus.data_word  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_read_frames();
        test_write_frames();
        test_full_write_under_stall();
        test_back_to_back();
        test_random_traffic();
        wait_for_drain();
        if (mismatch_count == 0 && frame_byte_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
